// ===== src/tcd_pkg.sv =====
// Types, code constants and the size table shared by the code decoder.
package tcd_pkg;

  localparam int unsigned CodeW = 8;
  localparam int unsigned AccW = 15;
  localparam int unsigned TotW = 32;
  localparam int unsigned MoveW = 16;
  localparam int unsigned StepW = 6;
  localparam int unsigned SizeW = 6;
  localparam int unsigned GlyphW = 7;
  localparam int unsigned KindW = 5;
  localparam int unsigned OutDataW = 112;

  // command codes
  localparam logic [CodeW-1:0] CodeNull = 8'o000;
  localparam logic [CodeW-1:0] CmdInit = 8'o100;
  localparam logic [CodeW-1:0] CmdLowerRail = 8'o101;
  localparam logic [CodeW-1:0] CmdUpperRail = 8'o102;
  localparam logic [CodeW-1:0] CmdUpperMag = 8'o103;
  localparam logic [CodeW-1:0] CmdLowerMag = 8'o104;
  localparam logic [CodeW-1:0] CmdLowerCase = 8'o105;
  localparam logic [CodeW-1:0] CmdUpperCase = 8'o106;
  localparam logic [CodeW-1:0] CmdEscFwd = 8'o107;
  localparam logic [CodeW-1:0] CmdEscBwd = 8'o110;
  localparam logic [CodeW-1:0] CmdStop = 8'o111;
  localparam logic [CodeW-1:0] CmdLeadFwd = 8'o112;
  localparam logic [CodeW-1:0] CmdLeadBwd = 8'o114;

  typedef enum logic [KindW-1:0] {
    EV_ESCAPE    = 5'd0,
    EV_NULL      = 5'd1,
    EV_INIT      = 5'd2,
    EV_LOWER_RAIL = 5'd3,
    EV_UPPER_RAIL = 5'd4,
    EV_UPPER_MAG = 5'd5,
    EV_LOWER_MAG = 5'd6,
    EV_LOWER_CASE = 5'd7,
    EV_UPPER_CASE = 5'd8,
    EV_ESC_FWD   = 5'd9,
    EV_ESC_BWD   = 5'd10,
    EV_STOP      = 5'd11,
    EV_LEAD_FWD  = 5'd12,
    EV_LEAD_BWD  = 5'd13,
    EV_UNDEF     = 5'd14,
    EV_LEAD      = 5'd15,
    EV_SIZE      = 5'd16,
    EV_CHAR      = 5'd17
  } event_kind_t;

  typedef enum logic [1:0] {
    DBL_NONE   = 2'd0,
    DBL_DOUBLE = 2'd1,
    DBL_SINGLE = 2'd2
  } dbl_change_t;

  typedef struct packed {
    logic [AccW-1:0] escape_accum;
    logic            escape_backward;
    logic            lead_backward;
    logic            upper_case;
    logic [1:0]      rail_mag;      // bit 0 upper rail, bit 1 upper magazine
    logic [TotW-1:0] escape_sum;
    logic [TotW-1:0] lead_sum;
    logic            double_mode;
  } dec_state_t;

  typedef struct packed {
    logic [CodeW-1:0]  raw_code;
    logic              escape_flushed;
    logic [MoveW-1:0]  escape_move;
    logic [TotW-1:0]   escape_total;
    event_kind_t       event_kind;
    logic [StepW-1:0]  lead_step;
    logic [TotW-1:0]   lead_total;
    logic [SizeW-1:0]  point_size;
    dbl_change_t       double_change;
    logic [GlyphW-1:0] glyph_index;
    logic              special_font;
  } dec_result_t;

  function automatic logic [SizeW-1:0] size_points(input logic [3:0] n);
    logic [SizeW-1:0] p;
    case (n)
      4'd0:    p = 6'd7;
      4'd1:    p = 6'd8;
      4'd2:    p = 6'd10;
      4'd3:    p = 6'd11;
      4'd4:    p = 6'd12;
      4'd5:    p = 6'd14;
      4'd6:    p = 6'd18;
      4'd7:    p = 6'd9;
      4'd8:    p = 6'd6;
      4'd9:    p = 6'd16;
      4'd10:   p = 6'd20;
      4'd11:   p = 6'd22;
      4'd12:   p = 6'd24;
      4'd13:   p = 6'd28;
      4'd14:   p = 6'd36;
      default: p = 6'd18;
    endcase
    return p;
  endfunction

endpackage

// ===== src/tcd_decode.sv =====
// Per-byte decode: next decoder state and the decoded event for one code byte.
module tcd_decode
  import tcd_pkg::*;
(
  input  logic [CodeW-1:0] code_byte,
  input  dec_state_t       cur,
  output dec_state_t       nxt,
  output dec_result_t      res
);

  logic [AccW:0]    acc_sum;
  logic [AccW-1:0]  acc_sat;
  logic [MoveW-1:0] move;
  logic [4:0]       lead_mag;
  logic [StepW-1:0] step;
  logic             new_dbl;

  // inverted low seven bits, saturate once the sum reaches bit 15
  assign acc_sum = {1'b0, cur.escape_accum} + {{(AccW-6){1'b0}}, ~code_byte[6:0]};
  assign acc_sat = acc_sum[AccW] ? {AccW{1'b1}} : acc_sum[AccW-1:0];
  assign move = cur.escape_backward ? (MoveW'(0) - {1'b0, cur.escape_accum})
                                    : {1'b0, cur.escape_accum};
  assign lead_mag = ~code_byte[4:0];
  assign step = cur.lead_backward ? (StepW'(0) - {1'b0, lead_mag}) : {1'b0, lead_mag};
  assign new_dbl = code_byte[3] & (code_byte[2:0] != 3'd0);

  always_comb begin
    nxt = cur;
    res = '0;
    res.raw_code = code_byte;
    res.event_kind = EV_ESCAPE;
    res.double_change = DBL_NONE;

    if (code_byte[7]) begin
      nxt.escape_accum = acc_sat;
    end else begin
      if (cur.escape_accum != '0) begin
        nxt.escape_sum = cur.escape_sum + {{(TotW-MoveW){move[MoveW-1]}}, move};
        nxt.escape_accum = '0;
        res.escape_move = move;
        res.escape_flushed = 1'b1;
      end
      if (code_byte == CodeNull) begin
        res.event_kind = EV_NULL;
      end else if (code_byte[6:4] == 3'b100) begin
        case (code_byte)
          CmdInit: begin
            nxt.escape_backward = 1'b0;
            nxt.lead_backward = 1'b0;
            nxt.upper_case = 1'b0;
            nxt.rail_mag = 2'b00;
            res.event_kind = EV_INIT;
          end
          CmdLowerRail: begin
            nxt.rail_mag[0] = 1'b0;
            res.event_kind = EV_LOWER_RAIL;
          end
          CmdUpperRail: begin
            nxt.rail_mag[0] = 1'b1;
            res.event_kind = EV_UPPER_RAIL;
          end
          CmdUpperMag: begin
            nxt.rail_mag[1] = 1'b1;
            res.event_kind = EV_UPPER_MAG;
          end
          CmdLowerMag: begin
            nxt.rail_mag[1] = 1'b0;
            res.event_kind = EV_LOWER_MAG;
          end
          CmdLowerCase: begin
            nxt.upper_case = 1'b0;
            res.event_kind = EV_LOWER_CASE;
          end
          CmdUpperCase: begin
            nxt.upper_case = 1'b1;
            res.event_kind = EV_UPPER_CASE;
          end
          CmdEscFwd: begin
            nxt.escape_backward = 1'b0;
            res.event_kind = EV_ESC_FWD;
          end
          CmdEscBwd: begin
            nxt.escape_backward = 1'b1;
            res.event_kind = EV_ESC_BWD;
          end
          CmdStop: res.event_kind = EV_STOP;
          CmdLeadFwd: begin
            nxt.lead_backward = 1'b0;
            res.event_kind = EV_LEAD_FWD;
          end
          CmdLeadBwd: begin
            nxt.lead_backward = 1'b1;
            res.event_kind = EV_LEAD_BWD;
          end
          default: res.event_kind = EV_UNDEF;
        endcase
      end else if (code_byte[6:5] == 2'b11) begin
        nxt.lead_sum = cur.lead_sum + {{(TotW-StepW){step[StepW-1]}}, step};
        res.lead_step = step;
        res.event_kind = EV_LEAD;
      end else if (code_byte[6:4] == 3'b101) begin
        res.point_size = size_points(code_byte[3:0]);
        if (!cur.double_mode && new_dbl) begin
          res.double_change = DBL_DOUBLE;
        end else if (cur.double_mode && !new_dbl) begin
          res.double_change = DBL_SINGLE;
        end
        nxt.double_mode = new_dbl;
        res.event_kind = EV_SIZE;
      end else begin
        res.glyph_index = {cur.upper_case, code_byte[5:0]};
        res.special_font = (cur.rail_mag == 2'b11);
        res.event_kind = EV_CHAR;
      end
    end

    res.escape_total = nxt.escape_sum;
    res.lead_total = nxt.lead_sum;
  end

endmodule

// ===== src/typesetter_code_decoder.sv =====
// Phototypesetter code decoder: one code byte in, one decoded event out.
// Registers: the input register holds the byte, the result register holds its decoded event.
// Throughput: one byte per cycle while out_tready keeps the result register draining;
// the decode and both 32-bit total adders sit in the single stage between the two registers.
// Reset (rst_n low, synchronous): both stages empty, accumulator, modes and totals cleared.
module typesetter_code_decoder
  import tcd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [CodeW-1:0]    in_tdata,   // [7:0] code_byte
  output logic                out_tvalid,
  input  logic                out_tready,
  // [7:0] raw_code, [8] escape_flushed, [24:9] escape_move, [56:25] escape_total,
  // [62:57] lead_step, [94:63] lead_total, [100:95] point_size,
  // [102:101] double_change, [109:103] glyph_index, [110] special_font, [111] zero
  output logic [OutDataW-1:0] out_tdata,
  output logic [KindW-1:0]    out_tuser   // [4:0] event_kind
);

  logic             in_valid_r;
  logic [CodeW-1:0] in_byte_r;
  logic             out_valid_r;
  dec_result_t      res_r;
  dec_result_t      res_nxt;
  dec_state_t       state_r;
  dec_state_t       state_nxt;
  logic             out_load;

  // result register takes a beat when empty or being drained this cycle
  assign out_load = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || out_load;

  tcd_decode u_decode (
    .code_byte (in_byte_r),
    .cur       (state_r),
    .nxt       (state_nxt),
    .res       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      state_r <= '0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
        state_r <= state_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
    if (out_load) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser = res_r.event_kind;
  assign out_tdata = {1'b0,
                      res_r.special_font,
                      res_r.glyph_index,
                      res_r.double_change,
                      res_r.point_size,
                      res_r.lead_total,
                      res_r.lead_step,
                      res_r.escape_total,
                      res_r.escape_move,
                      res_r.escape_flushed,
                      res_r.raw_code};

endmodule

// ===== verif/tb_typesetter_code_decoder.sv =====
// Testbench for the typesetter code decoder: directed and random code streams, self-checked.
`timescale 1ns / 100ps

module tb_typesetter_code_decoder;
  import tcd_pkg::*;

  localparam int IdleLimit = 1000;
  localparam int SettleCycles = 6;
  localparam int HoldCycles = 200;

  // code groups
  localparam logic [CodeW-1:0] CmdMask = 8'o360;
  localparam logic [CodeW-1:0] CmdBase = 8'o100;
  localparam logic [CodeW-1:0] LeadMask = 8'o340;
  localparam logic [CodeW-1:0] LeadBase = 8'o140;
  localparam logic [CodeW-1:0] SizeMask = 8'o360;
  localparam logic [CodeW-1:0] SizeBase = 8'o120;
  localparam logic [CodeW-1:0] CodeSpareA = 8'o113;
  localparam logic [CodeW-1:0] CodeSpareB = 8'o115;
  localparam logic [CodeW-1:0] CodeSpareC = 8'o116;
  localparam logic [CodeW-1:0] CodeSpareD = 8'o117;
  localparam logic [AccW-1:0] AccMax = 15'h7fff;

  // point sizes, entry n at bits [6n +: 6]
  localparam logic [16*SizeW-1:0] PointTable = {
    6'd18, 6'd36, 6'd28, 6'd24, 6'd22, 6'd20, 6'd16, 6'd6,
    6'd9,  6'd18, 6'd14, 6'd12, 6'd11, 6'd10, 6'd8,  6'd7
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [CodeW-1:0]    in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic [KindW-1:0]    out_tuser;

  // decoder state as predicted
  logic [AccW-1:0] esc_acc;
  logic            esc_bwd;
  logic            lead_bwd;
  logic            ucase;
  logic [1:0]      rail_mag;
  logic [TotW-1:0] esc_sum;
  logic [TotW-1:0] lead_sum;
  logic            dbl_mode;

  dec_result_t event_q[$];

  bit    idle_en = 1'b0;
  bit    stall_en = 1'b0;
  int    hold_len = 0;
  bit    hold_active = 1'b0;
  int    n_fail = 0;
  int    n_sent = 0;
  int    n_checked = 0;
  int    n_flush = 0;
  int    n_sat = 0;
  int    idle_cycles = 0;
  logic [17:0] kinds_seen = '0;

  typesetter_code_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #2 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void clear_decoder();
    esc_acc = '0;
    esc_bwd = 1'b0;
    lead_bwd = 1'b0;
    ucase = 1'b0;
    rail_mag = 2'b00;
    esc_sum = '0;
    lead_sum = '0;
    dbl_mode = 1'b0;
  endfunction

  // Advances the predicted decoder by one code byte and returns the event it should emit.
  function automatic dec_result_t decode_code(input logic [CodeW-1:0] code);
    dec_result_t r;
    logic [AccW:0]   acc_next;
    logic [TotW-1:0] mv;
    logic [TotW-1:0] step;
    logic [3:0]      n;
    logic            nd;
    r = '0;
    r.raw_code = code;
    r.event_kind = EV_ESCAPE;
    if (code[7]) begin
      acc_next = {1'b0, esc_acc} + {9'b0, ~code[6:0]};
      if (acc_next > {1'b0, AccMax}) begin
        esc_acc = AccMax;
        n_sat++;
      end else begin
        esc_acc = acc_next[AccW-1:0];
      end
    end else begin
      if (esc_acc != '0) begin
        mv = esc_bwd ? -{17'b0, esc_acc} : {17'b0, esc_acc};
        esc_sum = esc_sum + mv;
        r.escape_move = mv[MoveW-1:0];
        r.escape_flushed = 1'b1;
        esc_acc = '0;
      end
      if (code == CodeNull) begin
        r.event_kind = EV_NULL;
      end else if ((code & CmdMask) == CmdBase) begin
        case (code)
          CmdInit: begin
            esc_bwd = 1'b0;
            lead_bwd = 1'b0;
            ucase = 1'b0;
            rail_mag = 2'b00;
            r.event_kind = EV_INIT;
          end
          CmdLowerRail: begin rail_mag[0] = 1'b0; r.event_kind = EV_LOWER_RAIL; end
          CmdUpperRail: begin rail_mag[0] = 1'b1; r.event_kind = EV_UPPER_RAIL; end
          CmdUpperMag:  begin rail_mag[1] = 1'b1; r.event_kind = EV_UPPER_MAG; end
          CmdLowerMag:  begin rail_mag[1] = 1'b0; r.event_kind = EV_LOWER_MAG; end
          CmdLowerCase: begin ucase = 1'b0; r.event_kind = EV_LOWER_CASE; end
          CmdUpperCase: begin ucase = 1'b1; r.event_kind = EV_UPPER_CASE; end
          CmdEscFwd:    begin esc_bwd = 1'b0; r.event_kind = EV_ESC_FWD; end
          CmdEscBwd:    begin esc_bwd = 1'b1; r.event_kind = EV_ESC_BWD; end
          CmdStop:      r.event_kind = EV_STOP;
          CmdLeadFwd:   begin lead_bwd = 1'b0; r.event_kind = EV_LEAD_FWD; end
          CmdLeadBwd:   begin lead_bwd = 1'b1; r.event_kind = EV_LEAD_BWD; end
          default:      r.event_kind = EV_UNDEF;
        endcase
      end else if ((code & LeadMask) == LeadBase) begin
        step = {27'b0, ~code[4:0]};
        if (lead_bwd) step = -step;
        lead_sum = lead_sum + step;
        r.lead_step = step[StepW-1:0];
        r.event_kind = EV_LEAD;
      end else if ((code & SizeMask) == SizeBase) begin
        n = code[3:0];
        nd = (n >= 4'd9);
        r.point_size = PointTable[n*SizeW +: SizeW];
        if (!dbl_mode && nd) r.double_change = DBL_DOUBLE;
        else if (dbl_mode && !nd) r.double_change = DBL_SINGLE;
        dbl_mode = nd;
        r.event_kind = EV_SIZE;
      end else begin
        r.glyph_index = {ucase, code[5:0]};
        r.special_font = (rail_mag == 2'b11);
        r.event_kind = EV_CHAR;
      end
    end
    r.escape_total = esc_sum;
    r.lead_total = lead_sum;
    return r;
  endfunction

  // one beat on the input side; the event is predicted at acceptance
  task automatic send_code(input logic [CodeW-1:0] code);
    int gap;
    gap = idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= code;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    event_q.push_back(decode_code(code));
    n_sent++;
  endtask

  // sender stops and waits for every outstanding event
  task automatic drain_events();
    in_tvalid <= 1'b0;
    while (event_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic logic [CodeW-1:0] random_code();
    int r;
    r = $urandom_range(0, 99);
    if (r < 38) return CmdBase | 8'($urandom_range(0, 15));
    if (r < 52) return LeadBase | 8'($urandom_range(0, 31));
    if (r < 64) return SizeBase | 8'($urandom_range(0, 15));
    if (r < 94) return 8'($urandom_range(1, 63));
    if (r < 96) return CodeNull;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic compare_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
      n_fail++;
    end
  endtask

  always @(posedge clk) begin : event_check
    dec_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (event_q.size() == 0) begin
        $error("event beat with no expectation, raw_code 0x%0h", out_tdata[7:0]);
        n_fail++;
      end else begin
        want = event_q.pop_front();
        n_checked++;
        kinds_seen[want.event_kind] = 1'b1;
        if (want.escape_flushed) n_flush++;
        compare_field("raw_code", 32'(want.raw_code), 32'(out_tdata[7:0]));
        compare_field("escape_flushed", 32'(want.escape_flushed), 32'(out_tdata[8]));
        compare_field("escape_move", 32'(want.escape_move), 32'(out_tdata[24:9]));
        compare_field("escape_total", want.escape_total, out_tdata[56:25]);
        compare_field("event_kind", 32'(want.event_kind), 32'(out_tuser));
        compare_field("lead_step", 32'(want.lead_step), 32'(out_tdata[62:57]));
        compare_field("lead_total", want.lead_total, out_tdata[94:63]);
        compare_field("point_size", 32'(want.point_size), 32'(out_tdata[100:95]));
        compare_field("double_change", 32'(want.double_change), 32'(out_tdata[102:101]));
        compare_field("glyph_index", 32'(want.glyph_index), 32'(out_tdata[109:103]));
        compare_field("special_font", 32'(want.special_font), 32'(out_tdata[110]));
      end
    end
  end

  // receiver: random stalls, or one long hold-off on request
  initial begin : result_ready
    int n;
    while (!rst_n) @(posedge clk);
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        out_tready <= 1'b0;
        hold_active = 1'b1;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
        hold_active = 1'b0;
        out_tready <= 1'b1;
      end else if (stall_en) begin
        n = pick_gap();
        if (n > 0) begin
          out_tready <= 1'b0;
          repeat (n) @(posedge clk);
          out_tready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Timeout: no beat for %0d cycles, %0d events outstanding",
                 idle_cycles, event_q.size());
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic test_directed();
    logic [CodeW-1:0] seq [27];
    seq = '{8'o377, CodeNull, 8'o200, CmdInit, CmdUpperRail, CmdUpperMag, CmdUpperCase,
            8'o077, CmdLowerRail, CmdLowerMag, CmdLowerCase, 8'o001, CmdEscBwd, 8'o201,
            CmdStop, CmdLeadFwd, 8'o140, CmdLeadBwd, 8'o177, 8'o176, CodeSpareA,
            CodeSpareB, CodeSpareC, CodeSpareD, 8'o137, 8'o120, 8'o131};
    idle_en = 1'b0;
    stall_en = 1'b0;
    foreach (seq[i]) send_code(seq[i]);
    drain_events();
  endtask

  // long escape runs push the accumulator into saturation, both directions
  task automatic test_escape_saturation();
    idle_en = 1'b1;
    stall_en = 1'b1;
    send_code(CmdEscBwd);
    repeat (260) send_code(8'o200);
    send_code(8'o203);
    send_code(CmdEscFwd);
    repeat (259) send_code(8'o200);
    send_code(CodeNull);
    send_code(CmdInit);
    drain_events();
  endtask

  task automatic test_random_stream(input int count);
    int sent;
    int chunk;
    int run;
    int mode;
    sent = 0;
    chunk = 0;
    while (sent < count) begin
      if (sent >= chunk * 100) begin
        mode = (chunk == 2) ? 0 : $urandom_range(0, 3);
        idle_en = (mode == 1) || (mode == 2);
        stall_en = (mode == 1) || (mode == 3);
        chunk++;
      end
      if ($urandom_range(0, 99) < 22) begin
        // escape run, now and then long enough to build a large move
        run = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
        repeat (run) send_code(8'($urandom_range(128, 255)));
        sent += run;
      end else begin
        send_code(random_code());
        sent++;
      end
    end
    drain_events();
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    idle_en = 1'b0;
    stall_en = 1'b0;
    hold_len = HoldCycles;
    while (!hold_active) @(posedge clk);
    repeat (40) begin
      if ($urandom_range(0, 3) == 0) send_code(8'($urandom_range(128, 255)));
      else send_code(random_code());
    end
    drain_events();
  endtask

  initial begin
    clear_decoder();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_escape_saturation();
    test_random_stream(250);
    test_backpressure();
    drain_events();
    $display("Run covered %0d code bytes, %0d events checked, %0d escape flushes,",
             n_sent, n_checked, n_flush);
    $display("%0d saturating escape bytes, event kinds seen 0x%05h", n_sat, kinds_seen);
    if (n_fail == 0 && event_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
